FILE: hw/rtl/nlts_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the note list tone sequencer.
// No dependencies; every other file but nlts_ram refers to it by scoped names.
package nlts_pkg;

   // Note store geometry (depth is a power of two; pointers wrap)
   localparam int STORE_DEPTH    = 256;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int REC_W          = 24;
   localparam int MAX_WALK_STEPS = 16;
   localparam int STEP_W         = $clog2(MAX_WALK_STEPS);

   // Stream payload widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   // Record control codes; end and any other low code stop playback
   localparam logic [15:0] CODE_REST   = 16'h0000;
   localparam logic [15:0] CODE_TEMPO  = 16'h0001;
   localparam logic [15:0] CODE_GAP    = 16'h0002;
   localparam logic [15:0] CODE_REPEAT = 16'h0003;

   // Reset tempo and gap
   localparam logic [7:0] UNIT_RESET = 8'd16;
   localparam logic [7:0] GAP_RESET  = 8'd15;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UNIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP  = 8'd1;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_PLAY  = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_EVAL,
      ST_READ_OFS,
      ST_EVAL_OFS,
      ST_EMIT
   } state_type;

   // Controller -> datapath
   typedef struct packed {
      logic capture;
      logic decode;
      logic eval;
      logic rd_ofs;
      logic eval_ofs;
      logic load_out;
   } ctrl_cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic walk;
      logic ev_done;
      logic ev_ofs;
      logic last_step;
   } dp_status_type;

endpackage

FILE: hw/rtl/nlts_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nlts_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/nlts_ctrl.sv
`timescale 1ns / 1ps
// Sequencer controller: item handshake, record walk sequencing, result valid.
// Depends on nlts_pkg.
module nlts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  nlts_pkg::dp_status_type status,
   output nlts_pkg::ctrl_cmd_type  cmd
);

   nlts_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nlts_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = nlts_pkg::ST_DECODE;
         end
         nlts_pkg::ST_DECODE: begin
            state_in = status.walk ? nlts_pkg::ST_READ : nlts_pkg::ST_EMIT;
         end
         nlts_pkg::ST_READ: begin
            state_in = nlts_pkg::ST_EVAL;
         end
         nlts_pkg::ST_EVAL: begin
            priority if (status.ev_done)   state_in = nlts_pkg::ST_EMIT;
            else if (status.ev_ofs)        state_in = nlts_pkg::ST_READ_OFS;
            else if (status.last_step)     state_in = nlts_pkg::ST_EMIT;
            else                           state_in = nlts_pkg::ST_READ;
         end
         nlts_pkg::ST_READ_OFS: begin
            state_in = nlts_pkg::ST_EVAL_OFS;
         end
         nlts_pkg::ST_EVAL_OFS: begin
            state_in = status.last_step ? nlts_pkg::ST_EMIT : nlts_pkg::ST_READ;
         end
         nlts_pkg::ST_EMIT: begin
            if (out_free) state_in = nlts_pkg::ST_IDLE;
         end
         default: state_in = nlts_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         nlts_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         nlts_pkg::ST_DECODE:   cmd.decode   = 1'b1;
         nlts_pkg::ST_READ:     ;
         nlts_pkg::ST_EVAL:     cmd.eval     = 1'b1;
         nlts_pkg::ST_READ_OFS: cmd.rd_ofs   = 1'b1;
         nlts_pkg::ST_EVAL_OFS: cmd.eval_ofs = 1'b1;
         nlts_pkg::ST_EMIT:     cmd.load_out = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nlts_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

FILE: hw/rtl/nlts_dp.sv
`timescale 1ns / 1ps
// Sequencer datapath: note store, pointer/tempo/gap/repeat state, result register.
// Depends on nlts_pkg and nlts_ram.
module nlts_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [nlts_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_we,
   input  logic [nlts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nlts_pkg::CSR_DATA_W-1:0]   csr_data,
   input  nlts_pkg::ctrl_cmd_type            cmd,
   output nlts_pkg::dp_status_type           status,
   output logic [nlts_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int AW = nlts_pkg::ADDR_W;

   // captured item
   nlts_pkg::cmd_type cmd_ff;
   logic [7:0]        addr_ff;
   logic [15:0]       code_ff;
   logic [7:0]        len_ff;

   // playback state
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic              playing_ff, playing_in;
   logic [7:0]        rep_ff, rep_in;
   logic [7:0]        pend_ff, pend_in;
   logic [7:0]        unit_ff, unit_in;
   logic [7:0]        gap_ff, gap_in;
   logic [nlts_pkg::STEP_W-1:0] step_ff, step_in;

   // result being built
   logic        tone_ff, tone_in;
   logic [7:0]  cmp_ff, cmp_in;
   logic [1:0]  cks_ff, cks_in;
   logic        pre_ff, pre_in;
   logic [15:0] wait_ff, wait_in;
   logic        fin_ff, fin_in;

   logic [nlts_pkg::RSP_DATA_W-1:0] rsp_ff;

   // store access
   logic [nlts_pkg::REC_W-1:0] rd_data;
   logic [AW-1:0]              rd_addr;
   logic                       wr_en;
   logic [15:0]                rec_code;
   logic [7:0]                 rec_len;
   logic                       is_tone, is_ctl, rep_exit;
   logic [15:0]                dur;

   assign rd_addr = cmd.rd_ofs ? ptr_ff + AW'(1) : ptr_ff;
   assign wr_en   = cmd.decode && (cmd_ff == nlts_pkg::CMD_WRITE);

   nlts_ram #(
      .WIDTH(nlts_pkg::REC_W),
      .DEPTH(nlts_pkg::STORE_DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr_ff[AW-1:0]),
      .wr_data({code_ff, len_ff}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rec_code = rd_data[23:8];
   assign rec_len  = rd_data[7:0];
   assign is_tone  = (rec_code[15:8] != 8'd0) || (rec_code == nlts_pkg::CODE_REST);
   assign is_ctl   = (rec_code == nlts_pkg::CODE_TEMPO) || (rec_code == nlts_pkg::CODE_GAP) ||
                     (rec_code == nlts_pkg::CODE_REPEAT);
   assign rep_exit = (rec_len != 8'd0) && (rep_ff == rec_len);
   assign dur      = {8'd0, unit_ff} * {8'd0, rec_len};

   assign status.walk      = (cmd_ff == nlts_pkg::CMD_TICK) && playing_ff && (pend_ff == 8'd0);
   assign status.ev_done   = is_tone || !is_ctl;
   assign status.ev_ofs    = (rec_code == nlts_pkg::CODE_REPEAT) && !rep_exit;
   assign status.last_step = (step_ff == nlts_pkg::STEP_W'(nlts_pkg::MAX_WALK_STEPS - 1));

   always_comb begin
      ptr_in     = ptr_ff;
      playing_in = playing_ff;
      rep_in     = rep_ff;
      pend_in    = pend_ff;
      unit_in    = unit_ff;
      gap_in     = gap_ff;
      step_in    = step_ff;
      tone_in    = tone_ff;
      cmp_in     = cmp_ff;
      cks_in     = cks_ff;
      pre_in     = pre_ff;
      wait_in    = wait_ff;
      fin_in     = fin_ff;

      if (csr_we) begin
         if (csr_index == nlts_pkg::CSR_UNIT) unit_in = csr_data;
         if (csr_index == nlts_pkg::CSR_GAP)  gap_in  = csr_data;
      end

      if (cmd.decode) begin
         tone_in = 1'b0;
         cmp_in  = '0;
         cks_in  = '0;
         pre_in  = 1'b0;
         wait_in = '0;
         fin_in  = 1'b0;
         step_in = '0;
         unique case (cmd_ff)
            nlts_pkg::CMD_WRITE: ;
            nlts_pkg::CMD_PLAY: begin
               ptr_in     = addr_ff[AW-1:0];
               pend_in    = '0;
               rep_in     = '0;
               playing_in = 1'b1;
               wait_in    = 16'd1;
            end
            nlts_pkg::CMD_STOP: begin
               fin_in     = playing_ff;
               playing_in = 1'b0;
               pend_in    = '0;
            end
            nlts_pkg::CMD_TICK: begin
               if (playing_ff && (pend_ff != 8'd0)) begin
                  wait_in = {8'd0, pend_ff};
                  pend_in = '0;
               end
            end
            default: ;
         endcase
      end

      if (cmd.eval) begin
         priority if (is_tone) begin
            if (rec_code != nlts_pkg::CODE_REST) begin
               tone_in = 1'b1;
               cmp_in  = rec_code[15:8];
               cks_in  = rec_code[1:0];
               pre_in  = rec_code[7];
            end
            wait_in = (dur > {8'd0, gap_ff}) ? dur - {8'd0, gap_ff} : 16'd0;
            ptr_in  = ptr_ff + AW'(1);
            pend_in = gap_ff;
         end else if (rec_code == nlts_pkg::CODE_TEMPO) begin
            unit_in = rec_len;
            ptr_in  = ptr_ff + AW'(1);
         end else if (rec_code == nlts_pkg::CODE_GAP) begin
            gap_in = rec_len;
            ptr_in = ptr_ff + AW'(1);
         end else if (rec_code == nlts_pkg::CODE_REPEAT) begin
            if (rep_exit) begin
               rep_in = '0;
               ptr_in = ptr_ff + AW'(2);
            end else if (rec_len != 8'd0) begin
               rep_in = rep_ff + 8'd1;
            end
         end else begin
            // end record or unknown code
            playing_in = 1'b0;
            pend_in    = '0;
            fin_in     = 1'b1;
         end
         // walk cap on records that neither finish nor need the offset record
         if (!status.ev_done && !status.ev_ofs) begin
            if (status.last_step) begin
               playing_in = 1'b0;
               pend_in    = '0;
               fin_in     = 1'b1;
            end else begin
               step_in = step_ff + nlts_pkg::STEP_W'(1);
            end
         end
      end

      if (cmd.eval_ofs) begin
         // back offset is the next record modulo the store depth
         ptr_in = ptr_ff - rd_data[AW-1:0];
         if (status.last_step) begin
            playing_in = 1'b0;
            pend_in    = '0;
            fin_in     = 1'b1;
         end else begin
            step_in = step_ff + nlts_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         playing_ff <= 1'b0;
         rep_ff     <= '0;
         pend_ff    <= '0;
         unit_ff    <= nlts_pkg::UNIT_RESET;
         gap_ff     <= nlts_pkg::GAP_RESET;
         step_ff    <= '0;
      end else begin
         ptr_ff     <= ptr_in;
         playing_ff <= playing_in;
         rep_ff     <= rep_in;
         pend_ff    <= pend_in;
         unit_ff    <= unit_in;
         gap_ff     <= gap_in;
         step_ff    <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= nlts_pkg::cmd_type'(req_tdata[1:0]);
         addr_ff <= req_tdata[9:2];
         code_ff <= req_tdata[25:10];
         len_ff  <= req_tdata[33:26];
      end
      tone_ff <= tone_in;
      cmp_ff  <= cmp_in;
      cks_ff  <= cks_in;
      pre_ff  <= pre_in;
      wait_ff <= wait_in;
      fin_ff  <= fin_in;
      if (cmd.load_out) begin
         rsp_ff <= {2'b00, playing_ff, fin_ff, wait_ff, pre_ff, cks_ff, cmp_ff, tone_ff};
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

FILE: hw/rtl/note_list_tone_sequencer_core.sv
`timescale 1ns / 1ps
// Sequence: an accepted item passes ST_DECODE and ST_EMIT, then rsp_tvalid rises; a walking
//   tick adds ST_READ and ST_EVAL per record and ST_READ_OFS and ST_EVAL_OFS per looping
//   repeat, up to MAX_WALK_STEPS walk steps. One item at a time; the next item is taken
//   once the result sits in the output register, even while it waits for rsp_tready.
// Reset: synchronous, active high; idle, tempo 16 ms, gap 15 ms; note store contents undefined.
// Top level of the note list tone sequencer. Depends on nlts_pkg, nlts_ctrl, nlts_dp.
module note_list_tone_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] command, [9:2] address, [25:10] note_code, [33:26] note_length, [39:34] zero
   input  logic [nlts_pkg::REQ_DATA_W-1:0]   req_tdata,
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] tone_on, [8:1] compare_match, [10:9] clock_select, [11] prescale_bit,
   // [27:12] wait_ms, [28] finished, [29] busy_res, [31:30] zero
   output logic [nlts_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration writes: index 0 initial_unit_ms, index 1 initial_gap_ms
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nlts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nlts_pkg::CSR_DATA_W-1:0]   csr_data
);

   nlts_pkg::ctrl_cmd_type  cmd;
   nlts_pkg::dp_status_type status;

   // Writes must land only while idle; the block does not enforce this and always takes them;
   // a write also loads the live tempo or gap value.
   assign csr_ready = 1'b1;

   // Controller: handshake and record walk sequencing
   nlts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: note store, playback state, result register
   nlts_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_tdata(req_tdata),
      .csr_we   (csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_tdata(rsp_tdata)
   );

endmodule

FILE: hw/rtl/nlts_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the note list tone sequencer, bound to the top level.
// Depends on nlts_pkg and note_list_tone_sequencer_core.
module nlts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [nlts_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // one item in flight: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in work");

   // a finished result never reports busy
   a_fin_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[28] |-> !rsp_tdata[29])
      else $error("finished result still busy");

   // a tone only plays while busy
   a_tone_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[29])
      else $error("tone on while not playing");

endmodule

bind note_list_tone_sequencer_core nlts_checker u_nlts_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
